// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, reset-qualified, reporting by $error
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bbdg_pkg.sv =====
// ----------------------------------------------------------------------------
// bbdg_pkg
// shared types and constants of the bayer demosaic with channel gain
// ----------------------------------------------------------------------------
`default_nettype none

package bbdg_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int PIX_W      = 8;
    localparam int OUT_COL_W  = 10;
    localparam int OUT_ROW_W  = 12;

    // largest geometry the line stores and the position counters support
    localparam int LINE_PIXELS_MAX = 1024;
    localparam int FRAME_LINES_MAX = 4096;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_PHASE_COL    = 3'd2;
    localparam logic [2:0] REG_PHASE_ROW    = 3'd3;
    localparam logic [2:0] REG_RED_GAIN     = 3'd4;
    localparam logic [2:0] REG_GREEN_GAIN   = 3'd5;
    localparam logic [2:0] REG_BLUE_GAIN    = 3'd6;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd352;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd288;
    localparam logic [9:0]  RED_GAIN_RST     = 10'd384;
    localparam logic [9:0]  GREEN_GAIN_RST   = 10'd346;
    localparam logic [9:0]  BLUE_GAIN_RST    = 10'd461;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [12:0] frame_height;
        logic        phase_col;
        logic        phase_row;
        logic [9:0]  red_gain;
        logic [9:0]  green_gain;
        logic [9:0]  blue_gain;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/bayer_bilinear_demosaic_gain_top.sv =====
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_gain_top: bilinear bayer demosaic with channel gain
// a result is presented on the master stream after the transaction of raw
// pixel (row+1, col+1) that completes interior pixel (row, col), through the
// line store read, window, color and result registers; one raw pixel per cycle
// while the master stream is not stalled, set by one read and one write of each
// line store per pixel; synchronous active-low reset clears position and pipe
`default_nettype none
`include "assert_macros.svh"

module bayer_bilinear_demosaic_gain_top
    import bbdg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // slave stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] raw_pixel
    input  wire logic                  i_s_tuser,   // [0] frame_start
    // master stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [33:24] out_col, [45:34] out_row
    output logic [47:0]                o_m_tdata,
    output logic                       o_m_tlast,   // frame_end
    // configuration
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [CFG_ADDR_W-1:0] i_paddr,
    input  wire logic [CFG_DATA_W-1:0] i_pwdata,
    output logic      [CFG_DATA_W-1:0] o_prdata,
    output logic                       o_pready
);

    localparam int COL_W = $clog2(LINE_PIXELS_MAX);
    localparam int ROW_W = $clog2(FRAME_LINES_MAX);
    localparam int WC_W  = COL_W + 1;
    localparam int HC_W  = ROW_W + 1;

    t_cfg cfg;

    logic [WC_W-1:0] width_use;
    logic [HC_W-1:0] height_use;

    // position of the next raw pixel
    logic [COL_W-1:0] r_col_cnt;
    logic [ROW_W-1:0] r_row_cnt;
    logic [COL_W-1:0] n_col_cnt;
    logic [ROW_W-1:0] n_row_cnt;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [WC_W-1:0]  col_inc;
    logic [HC_W-1:0]  row_inc;

    logic s_acc;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy_out;
    logic adv1;
    logic adv2;
    logic adv3;

    logic                 emit0;
    logic                 fe0;
    logic                 bg0;
    logic                 same0;
    logic [OUT_COL_W-1:0] oc0;
    logic [OUT_ROW_W-1:0] orow0;

    // stage 1: line store read
    logic                 r_v1;
    t_pix                 r_pix1;
    logic [COL_W-1:0]     r_col1;
    logic                 r_emit1;
    logic                 r_fe1;
    logic                 r_bg1;
    logic                 r_same1;
    logic [OUT_COL_W-1:0] r_oc1;
    logic [OUT_ROW_W-1:0] r_orow1;
    // stage 2: window
    logic                 r_v2;
    logic                 r_emit2;
    logic                 r_fe2;
    logic                 r_bg2;
    logic                 r_same2;
    logic [OUT_COL_W-1:0] r_oc2;
    logic [OUT_ROW_W-1:0] r_orow2;
    // stage 3: interpolated colors
    logic                 r_v3;
    logic                 r_fe3;
    logic [OUT_COL_W-1:0] r_oc3;
    logic [OUT_ROW_W-1:0] r_orow3;
    // result register
    logic                 r_vout;
    logic                 r_fe_o;
    logic [OUT_COL_W-1:0] r_oc_o;
    logic [OUT_ROW_W-1:0] r_orow_o;

    t_pix lb_up;
    t_pix lb_mid;
    t_pix ip_red;
    t_pix ip_green;
    t_pix ip_blue;
    t_pix g_red;
    t_pix g_green;
    t_pix g_blue;

    bbdg_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // geometry in use, clamped to 3..max
    always_comb begin
        if (cfg.frame_width < 11'd3) begin
            width_use = WC_W'(3);
        end else if (32'(cfg.frame_width) > 32'(LINE_PIXELS_MAX)) begin
            width_use = WC_W'(LINE_PIXELS_MAX);
        end else begin
            width_use = WC_W'(cfg.frame_width);
        end
        if (cfg.frame_height < 13'd3) begin
            height_use = HC_W'(3);
        end else if (32'(cfg.frame_height) > 32'(FRAME_LINES_MAX)) begin
            height_use = HC_W'(FRAME_LINES_MAX);
        end else begin
            height_use = HC_W'(cfg.frame_height);
        end
    end

    // pipeline flow control
    assign rdy_out    = !r_vout || i_m_tready;
    assign rdy3       = !r_v3 || rdy_out;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_s_tready = rdy1;
    assign s_acc      = i_s_tvalid && rdy1;
    assign adv1       = r_v1 && rdy2;
    assign adv2       = r_v2 && rdy3;
    assign adv3       = r_v3 && rdy_out;

    // position of this pixel and of the next one
    assign cur_col = i_s_tuser ? '0 : r_col_cnt;
    assign cur_row = i_s_tuser ? '0 : r_row_cnt;
    assign col_inc = {1'b0, cur_col} + WC_W'(1);
    assign row_inc = {1'b0, cur_row} + HC_W'(1);

    always_comb begin
        n_col_cnt = col_inc[COL_W-1:0];
        n_row_cnt = cur_row;
        if (col_inc >= width_use) begin
            n_col_cnt = '0;
            n_row_cnt = (row_inc >= height_use) ? '0 : row_inc[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (s_acc) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // output site sits one line and one column behind the incoming pixel
    assign emit0 = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
    assign fe0   = (row_inc == height_use) && (col_inc == width_use);
    assign oc0   = OUT_COL_W'(32'(cur_col) - 32'd1);
    assign orow0 = OUT_ROW_W'(32'(cur_row) - 32'd1);
    assign bg0   = (~cur_row[0]) == cfg.phase_row;
    assign same0 = (~cur_col[0]) == cfg.phase_col;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_s_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2 && r_emit2;
            end
            if (rdy_out) begin
                r_vout <= r_v3;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_pix1  <= i_s_tdata;
            r_col1  <= cur_col;
            r_emit1 <= emit0;
            r_fe1   <= fe0;
            r_bg1   <= bg0;
            r_same1 <= same0;
            r_oc1   <= oc0;
            r_orow1 <= orow0;
        end
        if (adv1) begin
            r_emit2 <= r_emit1;
            r_fe2   <= r_fe1;
            r_bg2   <= r_bg1;
            r_same2 <= r_same1;
            r_oc2   <= r_oc1;
            r_orow2 <= r_orow1;
        end
        if (adv2) begin
            r_fe3   <= r_fe2;
            r_oc3   <= r_oc2;
            r_orow3 <= r_orow2;
        end
        if (adv3) begin
            r_fe_o   <= r_fe3;
            r_oc_o   <= r_oc3;
            r_orow_o <= r_orow3;
        end
    end

    bbdg_line_buf #(
        .DEPTH  (LINE_PIXELS_MAX),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_acc),
        .i_rd_addr (cur_col),
        .i_wr_en   (adv1),
        .i_wr_addr (r_col1),
        .i_wr_up   (lb_mid),
        .i_wr_mid  (r_pix1),
        .o_up      (lb_up),
        .o_mid     (lb_mid)
    );

    bbdg_interp u_interp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift    (adv1),
        .i_up       (lb_up),
        .i_mid      (lb_mid),
        .i_pix      (r_pix1),
        .i_load     (adv2),
        .i_bg_row   (r_bg2),
        .i_same_col (r_same2),
        .o_red      (ip_red),
        .o_green    (ip_green),
        .o_blue     (ip_blue)
    );

    bbdg_gain u_gain (
        .i_clk   (i_clk),
        .i_load  (adv3),
        .i_red   (ip_red),
        .i_green (ip_green),
        .i_blue  (ip_blue),
        .i_cfg   (cfg),
        .o_red   (g_red),
        .o_green (g_green),
        .o_blue  (g_blue)
    );

    assign o_m_tvalid = r_vout;
    assign o_m_tlast  = r_fe_o;
    assign o_m_tdata  = {2'b00, r_orow_o, r_oc_o, g_blue, g_green, g_red};

    `ASSERT_NEXT(a_sof_restarts_position, i_clk, i_rst_n, s_acc && i_s_tuser, (r_col_cnt == COL_W'(1)) && (r_row_cnt == '0), "frame start did not restart the position")
    `ASSERT_IMPLY(a_ready_when_out_free, i_clk, i_rst_n, !r_vout || i_m_tready, o_s_tready, "input stalled with a free result register")
    `ASSERT_NEXT(a_stage3_reaches_out, i_clk, i_rst_n, adv3, r_vout, "interpolated pixel lost before the result register")

endmodule

`default_nettype wire

// ===== hw/rtl/bbdg_cfg.sv =====
// ----------------------------------------------------------------------------
// bbdg_cfg
// apb register file: geometry, bayer phase and channel gains
// ----------------------------------------------------------------------------
`default_nettype none

module bbdg_cfg
    import bbdg_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic [CFG_ADDR_W-1:0] i_paddr,
    input  wire logic [CFG_DATA_W-1:0] i_pwdata,
    output logic      [CFG_DATA_W-1:0] o_prdata,
    output logic                       o_pready,
    output t_cfg                       o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx  = i_paddr[4:2];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  n_cfg.frame_width  = i_pwdata[10:0];
                REG_FRAME_HEIGHT: n_cfg.frame_height = i_pwdata[12:0];
                REG_PHASE_COL:    n_cfg.phase_col    = i_pwdata[0];
                REG_PHASE_ROW:    n_cfg.phase_row    = i_pwdata[0];
                REG_RED_GAIN:     n_cfg.red_gain     = i_pwdata[9:0];
                REG_GREEN_GAIN:   n_cfg.green_gain   = i_pwdata[9:0];
                REG_BLUE_GAIN:    n_cfg.blue_gain    = i_pwdata[9:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= FRAME_WIDTH_RST;
            r_cfg.frame_height <= FRAME_HEIGHT_RST;
            r_cfg.phase_col    <= 1'b0;
            r_cfg.phase_row    <= 1'b0;
            r_cfg.red_gain     <= RED_GAIN_RST;
            r_cfg.green_gain   <= GREEN_GAIN_RST;
            r_cfg.blue_gain    <= BLUE_GAIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  o_prdata = {21'd0, r_cfg.frame_width};
            REG_FRAME_HEIGHT: o_prdata = {19'd0, r_cfg.frame_height};
            REG_PHASE_COL:    o_prdata = {31'd0, r_cfg.phase_col};
            REG_PHASE_ROW:    o_prdata = {31'd0, r_cfg.phase_row};
            REG_RED_GAIN:     o_prdata = {22'd0, r_cfg.red_gain};
            REG_GREEN_GAIN:   o_prdata = {22'd0, r_cfg.green_gain};
            REG_BLUE_GAIN:    o_prdata = {22'd0, r_cfg.blue_gain};
            default:          o_prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bbdg_line_buf.sv =====
// ----------------------------------------------------------------------------
// bbdg_line_buf
// two line stores with registered read and same-address write forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module bbdg_line_buf
    import bbdg_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire t_pix              i_wr_up,
    input  wire t_pix              i_wr_mid,
    output t_pix                   o_up,
    output t_pix                   o_mid
);

    t_pix r_mem_upper  [DEPTH];
    t_pix r_mem_middle [DEPTH];
    t_pix r_rd_up;
    t_pix r_rd_mid;
    t_pix r_fwd_up;
    t_pix r_fwd_mid;
    logic r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_upper[i_wr_addr]  <= i_wr_up;
            r_mem_middle[i_wr_addr] <= i_wr_mid;
        end
        if (i_rd_en) begin
            r_rd_up  <= r_mem_upper[i_rd_addr];
            r_rd_mid <= r_mem_middle[i_rd_addr];
        end
    end

    // a read that meets the write of the same column picks up the new data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_up  <= i_wr_up;
            r_fwd_mid <= i_wr_mid;
        end
    end

    assign o_up  = r_fwd ? r_fwd_up  : r_rd_up;
    assign o_mid = r_fwd ? r_fwd_mid : r_rd_mid;

endmodule

`default_nettype wire

// ===== hw/rtl/bbdg_interp.sv =====
// ----------------------------------------------------------------------------
// bbdg_interp
// 3x3 window and bilinear reconstruction of the missing colors
// ----------------------------------------------------------------------------
`default_nettype none

module bbdg_interp
    import bbdg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_shift,
    input  wire t_pix i_up,
    input  wire t_pix i_mid,
    input  wire t_pix i_pix,
    input  wire logic i_load,
    input  wire logic i_bg_row,
    input  wire logic i_same_col,
    output t_pix      o_red,
    output t_pix      o_green,
    output t_pix      o_blue
);

    // [line: 0 oldest][column: 2 newest]
    t_pix       r_win [3][3];
    t_pix       r_red;
    t_pix       r_green;
    t_pix       r_blue;
    t_pix       n_red;
    t_pix       n_green;
    t_pix       n_blue;
    logic [8:0] vert;
    logic [8:0] horz;
    logic [9:0] diag;
    logic [9:0] cross_sum;
    t_pix       center;
    t_pix       vert_avg;
    t_pix       horz_avg;
    t_pix       diag_avg;
    t_pix       cross_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_up;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_pix;
        end
    end

    assign center    = r_win[1][1];
    assign vert      = {1'b0, r_win[0][1]} + {1'b0, r_win[2][1]};
    assign horz      = {1'b0, r_win[1][0]} + {1'b0, r_win[1][2]};
    assign diag      = {2'b00, r_win[0][0]} + {2'b00, r_win[0][2]}
                     + {2'b00, r_win[2][0]} + {2'b00, r_win[2][2]};
    assign cross_sum = {1'b0, vert} + {1'b0, horz};
    assign vert_avg  = vert[8:1];
    assign horz_avg  = horz[8:1];
    assign diag_avg  = diag[9:2];
    assign cross_avg = cross_sum[9:2];

    always_comb begin
        if (i_bg_row) begin
            if (i_same_col) begin
                n_green = center;    n_red = vert_avg;  n_blue = horz_avg;
            end else begin
                n_blue  = center;    n_green = cross_avg; n_red = diag_avg;
            end
        end else begin
            if (i_same_col) begin
                n_red   = center;    n_green = cross_avg; n_blue = diag_avg;
            end else begin
                n_green = center;    n_red = horz_avg;  n_blue = vert_avg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

// ===== hw/rtl/bbdg_gain.sv =====
// ----------------------------------------------------------------------------
// bbdg_gain
// per-channel q2.8 gain, truncation and saturation into the result register
// ----------------------------------------------------------------------------
`default_nettype none

module bbdg_gain
    import bbdg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_load,
    input  wire t_pix i_red,
    input  wire t_pix i_green,
    input  wire t_pix i_blue,
    input  wire t_cfg i_cfg,
    output t_pix      o_red,
    output t_pix      o_green,
    output t_pix      o_blue
);

    logic [17:0] prod_r;
    logic [17:0] prod_g;
    logic [17:0] prod_b;
    t_pix        r_red;
    t_pix        r_green;
    t_pix        r_blue;

    function automatic t_pix sat_shift(input logic [17:0] prod);
        t_pix res;
        if (prod[17:16] != 2'b00) begin
            res = '1;
        end else begin
            res = prod[15:8];
        end
        return res;
    endfunction

    assign prod_r = 18'(i_red)   * 18'(i_cfg.red_gain);
    assign prod_g = 18'(i_green) * 18'(i_cfg.green_gain);
    assign prod_b = 18'(i_blue)  * 18'(i_cfg.blue_gain);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_red   <= sat_shift(prod_r);
            r_green <= sat_shift(prod_g);
            r_blue  <= sat_shift(prod_b);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire
